@@ rtl/point_pair_geometry_unit_defines.svh @@
// assertion macros shared by the point pair geometry rtl
// needs a clock named i_clk and an active low reset named i_rst_n in scope
`ifndef POINT_PAIR_GEOMETRY_UNIT_DEFINES_SVH
`define POINT_PAIR_GEOMETRY_UNIT_DEFINES_SVH

// same-cycle implication
`define PPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ppg_pkg.sv @@
// constants and the arctangent table for the point pair geometry unit
// no dependencies
package ppg_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int ANGLE_FRAC_DEF  = 13;
    localparam int CORDIC_STEPS    = 30;
    localparam int CORDIC_W        = 64;
    localparam int ACC_W           = 36;
    localparam int ACC_FRAC        = 30;
    localparam int NORM_MSB        = 59;
    localparam int SHIFT_W         = 6;
    localparam logic signed [ACC_W-1:0] PI_Q30 = 36'sd3373259426;

    // atan(2^-idx) in units of 2^-30 rad
    function automatic logic signed [ACC_W-1:0] atan_q30(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = 36'sd843314857;
            1:  v = 36'sd497837829;
            2:  v = 36'sd263043836;
            3:  v = 36'sd133525158;
            4:  v = 36'sd67021686;
            5:  v = 36'sd33543515;
            6:  v = 36'sd16775850;
            7:  v = 36'sd8388437;
            8:  v = 36'sd4194282;
            9:  v = 36'sd2097149;
            10: v = 36'sd1048575;
            11: v = 36'sd524287;
            12: v = 36'sd262143;
            13: v = 36'sd131072;
            14: v = 36'sd65536;
            15: v = 36'sd32768;
            16: v = 36'sd16384;
            17: v = 36'sd8192;
            18: v = 36'sd4096;
            19: v = 36'sd2048;
            20: v = 36'sd1024;
            21: v = 36'sd512;
            22: v = 36'sd256;
            23: v = 36'sd128;
            24: v = 36'sd64;
            25: v = 36'sd32;
            26: v = 36'sd16;
            27: v = 36'sd8;
            28: v = 36'sd4;
            29: v = 36'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/point_pair_geometry_unit.sv @@
// top level of the point pair geometry unit: stream ports, stage chains, output register
// uses ppg_pkg, ppg_front, ppg_sqrt_step, ppg_cordic_step and the assertion macros
//
// Takes one pair of 3D points per beat and returns the floored space and plan distances,
// the height change and the rounded azimuth. One pair is accepted every clock cycle while
// the pipeline does not hold; the front end feeds a chain of step stages that carries the
// 30 cordic iterations, one per stage, with the root digits running alongside. When the
// result beat is not taken the whole pipeline holds, and s_axis_tready follows it.
`include "point_pair_geometry_unit_defines.svh"

module point_pair_geometry_unit #(
    parameter int COORD_BITS      = ppg_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ppg_pkg::ANGLE_FRAC_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // space_distance, plan_distance, height_change, azimuth_angle
    output logic [((3*(COORD_BITS+1)+ANGLE_FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
    import ppg_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int NS     = C + 1;
    localparam int RW     = 2 * NS;
    localparam int AW     = ANGLE_FRAC_BITS + 3;
    localparam int RS     = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int L      = (NS > CORDIC_STEPS) ? NS : CORDIC_STEPS;
    localparam int DEPTH  = 4 + L + 1;
    localparam int OUT_W  = 3 * NS + AW;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (RS - 1);
    localparam logic signed [AW-1:0] PI_CODE = AW'((PI_Q30 + HALF) >>> RS);

    logic              w_en;
    logic [DEPTH-1:0]  r_vld;

    logic [RW-1:0]     w_plan_sum, w_space_sum;
    logic signed [C:0] w_dz;
    logic              w_zero;

    logic [RW-1:0]     w_prad  [0:L];
    logic [NS:0]       w_prem  [0:L];
    logic [NS-1:0]     w_proot [0:L];
    logic [RW-1:0]     w_srad  [0:L];
    logic [NS:0]       w_srem  [0:L];
    logic [NS-1:0]     w_sroot [0:L];
    logic signed [CORDIC_W-1:0] w_cx [0:L];
    logic signed [CORDIC_W-1:0] w_cy [0:L];
    logic signed [ACC_W-1:0]    w_cz [0:L];

    logic signed [C:0] r_dz_dly   [0:L-1];
    logic              r_zero_dly [0:L-1];

    logic [NS-1:0]     r_space_out, r_plan_out;
    logic signed [C:0] r_dz_out;
    logic signed [AW-1:0] r_angle_out;
    logic signed [ACC_W-1:0] n_zr;

    // the output register frees a slot whenever it is empty or being drained
    assign w_en          = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    ppg_front #(.COORD_BITS(C)) u_front (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_first_x  (s_axis_tdata[0*C +: C]),
        .i_first_y  (s_axis_tdata[1*C +: C]),
        .i_first_z  (s_axis_tdata[2*C +: C]),
        .i_second_x (s_axis_tdata[3*C +: C]),
        .i_second_y (s_axis_tdata[4*C +: C]),
        .i_second_z (s_axis_tdata[5*C +: C]),
        .o_plan_sum (w_plan_sum),
        .o_space_sum(w_space_sum),
        .o_dz       (w_dz),
        .o_zero     (w_zero),
        .o_cx       (w_cx[0]),
        .o_cy       (w_cy[0]),
        .o_cz       (w_cz[0])
    );

    assign w_prad[0]  = w_plan_sum;
    assign w_prem[0]  = '0;
    assign w_proot[0] = '0;
    assign w_srad[0]  = w_space_sum;
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;

    for (genvar k = 0; k < L; k++) begin : g_step
        ppg_sqrt_step #(.NS(NS), .ACTIVE(k < NS)) u_plan (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rad (w_prad[k]),
            .i_rem (w_prem[k]),
            .i_root(w_proot[k]),
            .o_rad (w_prad[k+1]),
            .o_rem (w_prem[k+1]),
            .o_root(w_proot[k+1])
        );
        ppg_sqrt_step #(.NS(NS), .ACTIVE(k < NS)) u_space (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rad (w_srad[k]),
            .i_rem (w_srem[k]),
            .i_root(w_sroot[k]),
            .o_rad (w_srad[k+1]),
            .o_rem (w_srem[k+1]),
            .o_root(w_sroot[k+1])
        );
        ppg_cordic_step #(.IDX(k), .ACTIVE(k < CORDIC_STEPS)) u_cordic (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_x  (w_cx[k]),
            .i_y  (w_cy[k]),
            .i_z  (w_cz[k]),
            .o_x  (w_cx[k+1]),
            .o_y  (w_cy[k+1]),
            .o_z  (w_cz[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dz_dly[0]   <= w_dz;
            r_zero_dly[0] <= w_zero;
            for (int i = 1; i < L; i++) begin
                r_dz_dly[i]   <= r_dz_dly[i-1];
                r_zero_dly[i] <= r_zero_dly[i-1];
            end
        end
    end

    // round to nearest, halfway toward plus infinity
    assign n_zr = w_cz[L] + HALF;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_space_out <= w_sroot[L];
            r_plan_out  <= w_proot[L];
            r_dz_out    <= r_dz_dly[L-1];
            r_angle_out <= r_zero_dly[L-1] ? '0 : AW'(n_zr >>> RS);
        end
    end

    assign m_axis_tdata = OUT_TW'({r_angle_out, r_dz_out, r_plan_out, r_space_out});

    `PPG_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, r_vld[0], "accepted beat lost at pipeline entry")
    `PPG_ASSERT_NOW(a_plan_le_space, m_axis_tvalid, r_plan_out <= r_space_out, "plan distance exceeds space distance")
    `PPG_ASSERT_NOW(a_angle_range, m_axis_tvalid, (r_angle_out <= PI_CODE) && (r_angle_out >= -PI_CODE), "azimuth outside of plus or minus pi")

endmodule

@@ rtl/ppg_front.sv @@
// front end: differences, squares, sums, quadrant fold and normalization
// four register stages; uses ppg_pkg
module ppg_front #(
    parameter int COORD_BITS = ppg_pkg::COORD_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic signed [COORD_BITS-1:0]              i_first_x,
    input  logic signed [COORD_BITS-1:0]              i_first_y,
    input  logic signed [COORD_BITS-1:0]              i_first_z,
    input  logic signed [COORD_BITS-1:0]              i_second_x,
    input  logic signed [COORD_BITS-1:0]              i_second_y,
    input  logic signed [COORD_BITS-1:0]              i_second_z,
    output logic [2*COORD_BITS+1:0]                   o_plan_sum,
    output logic [2*COORD_BITS+1:0]                   o_space_sum,
    output logic signed [COORD_BITS:0]                o_dz,
    output logic                                      o_zero,
    output logic signed [ppg_pkg::CORDIC_W-1:0]       o_cx,
    output logic signed [ppg_pkg::CORDIC_W-1:0]       o_cy,
    output logic signed [ppg_pkg::ACC_W-1:0]          o_cz
);
    import ppg_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int RW = 2 * C + 2;

    // stage 1
    logic signed [C:0] r_dx1, r_dy1, r_dz1;
    // stage 2
    logic [2*C-1:0]    r_sqx2, r_sqy2, r_sqz2;
    logic signed [C:0] r_fx2, r_fy2, r_dz2;
    logic [C-1:0]      r_mag2;
    logic signed [ACC_W-1:0] r_z2;
    logic              r_zero2;
    // stage 3
    logic [2*C:0]      r_plan3;
    logic [2*C-1:0]    r_sqz3;
    logic [SHIFT_W-1:0] r_sh3;
    logic signed [C:0] r_fx3, r_fy3, r_dz3;
    logic signed [ACC_W-1:0] r_z3;
    logic              r_zero3;
    // stage 4
    logic [RW-1:0]     r_plan4, r_space4;
    logic signed [C:0] r_dz4;
    logic              r_zero4;
    logic signed [CORDIC_W-1:0] r_cx4, r_cy4;
    logic signed [ACC_W-1:0] r_z4;

    logic signed [C:0] n_fx, n_fy;
    logic [C-1:0]      n_ax, n_ay, n_az, n_afx, n_afy;
    logic [SHIFT_W-1:0] n_msb;
    logic signed [CORDIC_W-1:0] n_ex, n_ey;

    always_comb begin
        n_ax = r_dx1[C] ? C'(-r_dx1) : C'(r_dx1);
        n_ay = r_dy1[C] ? C'(-r_dy1) : C'(r_dy1);
        n_az = r_dz1[C] ? C'(-r_dz1) : C'(r_dz1);
        // fold the left half plane onto the right one
        n_fx = r_dx1[C] ? -r_dx1 : r_dx1;
        n_fy = r_dx1[C] ? -r_dy1 : r_dy1;
        n_afx = C'(n_fx);
        n_afy = n_fy[C] ? C'(-n_fy) : C'(n_fy);
        n_msb = '0;
        for (int i = 0; i < C; i++) begin
            if (r_mag2[i]) n_msb = SHIFT_W'(i);
        end
        n_ex = {{(CORDIC_W-C-1){r_fx3[C]}}, r_fx3};
        n_ey = {{(CORDIC_W-C-1){r_fy3[C]}}, r_fy3};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx1 <= {i_second_x[C-1], i_second_x} - {i_first_x[C-1], i_first_x};
            r_dy1 <= {i_second_y[C-1], i_second_y} - {i_first_y[C-1], i_first_y};
            r_dz1 <= {i_second_z[C-1], i_second_z} - {i_first_z[C-1], i_first_z};

            r_sqx2  <= n_ax * n_ax;
            r_sqy2  <= n_ay * n_ay;
            r_sqz2  <= n_az * n_az;
            r_fx2   <= n_fx;
            r_fy2   <= n_fy;
            r_dz2   <= r_dz1;
            r_mag2  <= (n_afy > n_afx) ? n_afy : n_afx;
            r_zero2 <= (r_dx1 == '0) && (r_dy1 == '0);
            if (r_dx1[C]) begin
                r_z2 <= r_dy1[C] ? -PI_Q30 : PI_Q30;
            end else begin
                r_z2 <= '0;
            end

            r_plan3 <= {1'b0, r_sqx2} + {1'b0, r_sqy2};
            r_sqz3  <= r_sqz2;
            r_sh3   <= SHIFT_W'(NORM_MSB) - n_msb;
            r_fx3   <= r_fx2;
            r_fy3   <= r_fy2;
            r_dz3   <= r_dz2;
            r_z3    <= r_z2;
            r_zero3 <= r_zero2;

            r_plan4  <= RW'(r_plan3);
            r_space4 <= RW'(r_plan3) + RW'(r_sqz3);
            r_dz4    <= r_dz3;
            r_zero4  <= r_zero3;
            r_cx4    <= n_ex <<< r_sh3;
            r_cy4    <= n_ey <<< r_sh3;
            r_z4     <= r_z3;
        end
    end

    assign o_plan_sum  = r_plan4;
    assign o_space_sum = r_space4;
    assign o_dz        = r_dz4;
    assign o_zero      = r_zero4;
    assign o_cx        = r_cx4;
    assign o_cy        = r_cy4;
    assign o_cz        = r_z4;

endmodule

@@ rtl/ppg_sqrt_step.sv @@
// one digit of the restoring integer square root, registered
// uses ppg_pkg only for the default of NS
module ppg_sqrt_step #(
    parameter int NS     = ppg_pkg::COORD_BITS_DEF + 1,
    parameter bit ACTIVE = 1'b1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*NS-1:0]   i_rad,
    input  logic [NS:0]       i_rem,
    input  logic [NS-1:0]     i_root,
    output logic [2*NS-1:0]   o_rad,
    output logic [NS:0]       o_rem,
    output logic [NS-1:0]     o_root
);
    import ppg_pkg::*;

    logic [2*NS-1:0] r_rad;
    logic [NS:0]     r_rem;
    logic [NS-1:0]   r_root;
    logic [NS+2:0]   n_trem, n_trial;
    logic            n_fit;

    always_comb begin
        n_trem  = {i_rem, i_rad[2*NS-1 -: 2]};
        n_trial = {1'b0, i_root, 2'b01};
        n_fit   = n_trem >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (ACTIVE) begin
                r_rad  <= i_rad << 2;
                r_rem  <= n_fit ? (NS+1)'(n_trem - n_trial) : (NS+1)'(n_trem);
                r_root <= {i_root[NS-2:0], n_fit};
            end else begin
                r_rad  <= i_rad;
                r_rem  <= i_rem;
                r_root <= i_root;
            end
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ rtl/ppg_cordic_step.sv @@
// one vectoring iteration of the arctangent cordic, registered
// uses ppg_pkg for widths and the arctangent table
module ppg_cordic_step #(
    parameter int IDX    = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ppg_pkg::CORDIC_W-1:0]  i_x,
    input  logic signed [ppg_pkg::CORDIC_W-1:0]  i_y,
    input  logic signed [ppg_pkg::ACC_W-1:0]     i_z,
    output logic signed [ppg_pkg::CORDIC_W-1:0]  o_x,
    output logic signed [ppg_pkg::CORDIC_W-1:0]  o_y,
    output logic signed [ppg_pkg::ACC_W-1:0]     o_z
);
    import ppg_pkg::*;

    localparam logic signed [ACC_W-1:0] ANG = atan_q30(IDX);

    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ACC_W-1:0]    r_z;
    logic signed [CORDIC_W-1:0] n_xs, n_ys;

    always_comb begin
        n_xs = i_x >>> IDX;
        n_ys = i_y >>> IDX;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!ACTIVE) begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_z;
            end else if (!i_y[CORDIC_W-1]) begin
                r_x <= i_x + n_ys;
                r_y <= i_y - n_xs;
                r_z <= i_z + ANG;
            end else begin
                r_x <= i_x - n_ys;
                r_y <= i_y + n_xs;
                r_z <= i_z - ANG;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
